>>> src/lsaf_pkg.sv
// Shared types and constants for the lidar/sonar altitude fusion core.
// Holds the item structs, register indexes, back-end states and fixed widths.
// No dependencies.
package lsaf_pkg;

	localparam int LIDAR_W = 12;
	localparam int SONAR_W = 11;
	localparam int ALT_W = 13;
	localparam int OFFSET_W = 8;
	localparam int AGREE_W = 10;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 10;

	localparam int DEF_AVERAGE_DEPTH = 5;
	localparam int DEF_QUEUE_DEPTH = 2;

	localparam logic [AGREE_W-1:0] AGREE_RESET = 10'd50;
	localparam logic [SONAR_W-1:0] SONAR_OOR = 11'd1068;
	localparam logic [LIDAR_W-1:0] LIDAR_OOR = 12'd0;
	localparam logic signed [ALT_W-1:0] ALT_NONE = -13'sd1;

	// Division by ten as a multiply by a scaled reciprocal, exact for 16-bit operands.
	localparam int RECIP_W = 16;
	localparam logic [RECIP_W-1:0] RECIP_10 = 16'd52429;
	localparam int RECIP_SHIFT = 19;
	localparam int PROD_W = 2 * RECIP_W;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_LIDAR_OFFSET = 2'd0,
		CFG_SONAR_OFFSET = 2'd1,
		CFG_AGREEMENT_WINDOW = 2'd2
	} cfg_reg_e;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_CLAMP,
		ST_SCALE,
		ST_OUT
	} back_state_t;

	typedef struct packed {
		logic lidar_present;
		logic lidar_fault;
		logic [LIDAR_W-1:0] lidar_sample;
		logic sonar_present;
		logic sonar_fault;
		logic [SONAR_W-1:0] sonar_sample;
	} in_item_t;

	typedef struct packed {
		logic signed [ALT_W-1:0] altitude;
		logic [LIDAR_W-1:0] lidar_filtered;
		logic [SONAR_W-1:0] sonar_filtered;
		logic discrepancy;
	} res_item_t;

	typedef struct packed {
		logic l_push;
		logic s_push;
		logic l_present;
		logic s_present;
		logic l_oor;
		logic s_oor;
		logic [LIDAR_W-1:0] l_sample;
		logic [SONAR_W-1:0] s_sample;
	} cmd_t;

endpackage

>>> src/lsaf_queue.sv
// Small first-in first-out queue of registers with full and empty flags.
// Used between the front and back ends and on the result side; uses lsaf_pkg.
module lsaf_queue
	import lsaf_pkg::*;
#(
	parameter int W = 8,
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

>>> src/lsaf_front.sv
// Front end: accepts input items and classifies each sample for the back end.
// Feeds the command queue; uses lsaf_pkg.
module lsaf_front
	import lsaf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  in_item_t sample,
	output logic     full,
	output logic     cmd_push,
	output cmd_t     cmd,
	input  logic     cmd_full
);

	logic vld_s1;
	cmd_t cmd_s1;
	cmd_t cls;
	logic accept;

	assign full = vld_s1 && cmd_full;
	assign accept = push && !full;
	assign cmd_push = vld_s1;
	assign cmd = cmd_s1;

	always_comb begin
		cls.l_push = sample.lidar_present && !sample.lidar_fault;
		cls.s_push = sample.sonar_present && !sample.sonar_fault;
		cls.l_present = sample.lidar_present;
		cls.s_present = sample.sonar_present;
		cls.l_oor = (sample.lidar_sample == LIDAR_OOR);
		cls.s_oor = (sample.sonar_sample == SONAR_OOR);
		cls.l_sample = sample.lidar_sample;
		cls.s_sample = sample.sonar_sample;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (!cmd_full) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cls;
		end
	end

endmodule

>>> src/lsaf_div.sv
// Restoring unsigned divider that retires two quotient bits per cycle.
// Used by the back end to form window means; uses lsaf_pkg.
module lsaf_div
	import lsaf_pkg::*;
#(
	parameter int DW = 16,
	parameter int VW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int STEPS = (DW + 1) / 2;
	localparam int PW = 2 * STEPS;
	localparam int CW = $clog2(STEPS + 1);

	logic [PW-1:0] quo_q;
	logic [VW:0] rem_q;
	logic [VW-1:0] div_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [PW-1:0] quo_nx;
	logic [VW:0] rem_nx;

	always_comb begin
		logic [VW:0] r;
		logic [PW-1:0] d;
		r = rem_q;
		d = quo_q;
		for (int k = 0; k < 2; k++) begin
			r = {r[VW-1:0], d[PW-1]};
			d = {d[PW-2:0], 1'b0};
			if (r >= {1'b0, div_q}) begin
				r = r - {1'b0, div_q};
				d[0] = 1'b1;
			end
		end
		rem_nx = r;
		quo_nx = d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			done_q <= (cnt_q == CW'(STEPS - 1));
			busy_q <= (cnt_q != CW'(STEPS - 1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= PW'(dividend);
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= quo_nx;
			rem_q <= rem_nx;
		end
	end

	assign done = done_q;
	assign quotient = quo_q[DW-1:0];

endmodule

>>> src/lsaf_back.sv
// Back end: moving-average windows, offset clamp and fusion rules.
// Holds the configuration registers; uses lsaf_pkg and lsaf_div.
module lsaf_back
	import lsaf_pkg::*;
#(
	parameter int AVERAGE_DEPTH = DEF_AVERAGE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wen,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   cmd_empty,
	output logic                   cmd_pop,
	input  cmd_t                   cmd,
	input  logic                   res_full,
	output logic                   res_push,
	output res_item_t              res
);

	localparam int SLOT_W = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
	localparam int FILL_W = $clog2(AVERAGE_DEPTH + 1);
	localparam int LSUM_W = LIDAR_W + $clog2(AVERAGE_DEPTH);
	localparam int SSUM_W = SONAR_W + $clog2(AVERAGE_DEPTH);

	back_state_t state_q, state_nx;

	logic [OFFSET_W-1:0] loff_q, soff_q;
	logic [AGREE_W-1:0] agree_q;

	logic [LIDAR_W-1:0] lwin_q [AVERAGE_DEPTH];
	logic [SONAR_W-1:0] swin_q [AVERAGE_DEPTH];
	logic [SLOT_W-1:0] lslot_q, sslot_q;
	logic [FILL_W-1:0] lfill_q, sfill_q;
	logic [LSUM_W-1:0] lsum_q;
	logic [SSUM_W-1:0] ssum_q;

	logic lfull, sfull;
	logic [LSUM_W-1:0] lsum_nx;
	logic [SSUM_W-1:0] ssum_nx;
	logic [FILL_W-1:0] lfill_nx, sfill_nx;

	logic lp_q, sp_q, loor_q, soor_q;
	logic [LIDAR_W-1:0] lfilt_q;
	logic [SONAR_W-1:0] sfilt_q;
	logic diff_le_q, diff_ge_q;
	logic [PROD_W-1:0] lprod_q, sprod_q;

	logic l_done, s_done;
	logic [LSUM_W-1:0] lquo, squo;
	logic [LIDAR_W-1:0] lmean, diff;
	logic [SONAR_W-1:0] smean;
	logic [RECIP_W-1:0] l9;
	logic signed [ALT_W-1:0] blend, alt;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loff_q <= '0;
			soff_q <= '0;
			agree_q <= AGREE_RESET;
		end else if (cfg_wen) begin
			case (cfg_reg_e'(cfg_index))
				CFG_LIDAR_OFFSET: loff_q <= cfg_data[OFFSET_W-1:0];
				CFG_SONAR_OFFSET: soff_q <= cfg_data[OFFSET_W-1:0];
				CFG_AGREEMENT_WINDOW: agree_q <= cfg_data[AGREE_W-1:0];
				default: ;
			endcase
		end
	end

	// Running sums: an entry not yet filled counts as zero.
	assign lfull = (lfill_q == FILL_W'(AVERAGE_DEPTH));
	assign sfull = (sfill_q == FILL_W'(AVERAGE_DEPTH));

	always_comb begin
		lsum_nx = lsum_q;
		lfill_nx = lfill_q;
		if (cmd.l_push) begin
			lsum_nx = lsum_q + LSUM_W'(cmd.l_sample)
				- (lfull ? LSUM_W'(lwin_q[lslot_q]) : LSUM_W'(0));
			lfill_nx = lfull ? lfill_q : lfill_q + 1'b1;
		end
		ssum_nx = ssum_q;
		sfill_nx = sfill_q;
		if (cmd.s_push) begin
			ssum_nx = ssum_q + SSUM_W'(cmd.s_sample)
				- (sfull ? SSUM_W'(swin_q[sslot_q]) : SSUM_W'(0));
			sfill_nx = sfull ? sfill_q : sfill_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lsum_q <= '0;
			ssum_q <= '0;
			lfill_q <= '0;
			sfill_q <= '0;
			lslot_q <= '0;
			sslot_q <= '0;
		end else if (cmd_pop) begin
			lsum_q <= lsum_nx;
			ssum_q <= ssum_nx;
			lfill_q <= lfill_nx;
			sfill_q <= sfill_nx;
			if (cmd.l_push) begin
				lslot_q <= (lslot_q == SLOT_W'(AVERAGE_DEPTH - 1)) ? '0 : lslot_q + 1'b1;
			end
			if (cmd.s_push) begin
				sslot_q <= (sslot_q == SLOT_W'(AVERAGE_DEPTH - 1)) ? '0 : sslot_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.l_push) begin
			lwin_q[lslot_q] <= cmd.l_sample;
		end
		if (cmd_pop && cmd.s_push) begin
			swin_q[sslot_q] <= cmd.s_sample;
		end
	end

	lsaf_div #(.DW(LSUM_W), .VW(FILL_W)) u_ldiv (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd_pop),
		.dividend(lsum_nx),
		.divisor(lfill_nx),
		.done(l_done),
		.quotient(lquo)
	);

	lsaf_div #(.DW(LSUM_W), .VW(FILL_W)) u_sdiv (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd_pop),
		.dividend(LSUM_W'(ssum_nx)),
		.divisor(sfill_nx),
		.done(s_done),
		.quotient(squo)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd_pop = 1'b0;
		res_push = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					state_nx = ST_DIV;
				end
			end
			ST_DIV: begin
				if (l_done && s_done) begin
					state_nx = ST_CLAMP;
				end
			end
			ST_CLAMP: state_nx = ST_SCALE;
			ST_SCALE: state_nx = ST_OUT;
			ST_OUT: begin
				if (!res_full) begin
					res_push = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// Datapath.
	assign lmean = (lfill_q == '0) ? '0 : lquo[LIDAR_W-1:0];
	assign smean = (sfill_q == '0) ? '0 : squo[SONAR_W-1:0];
	assign diff = (lfilt_q > LIDAR_W'(sfilt_q)) ? lfilt_q - LIDAR_W'(sfilt_q)
		: LIDAR_W'(sfilt_q) - lfilt_q;
	assign l9 = {1'b0, lfilt_q, 3'b000} + RECIP_W'(lfilt_q);

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			lp_q <= cmd.l_present;
			sp_q <= cmd.s_present;
			loor_q <= cmd.l_oor;
			soor_q <= cmd.s_oor;
		end
		if (state_q == ST_CLAMP) begin
			lfilt_q <= (lmean > LIDAR_W'(loff_q)) ? lmean - LIDAR_W'(loff_q) : '0;
			sfilt_q <= (smean > SONAR_W'(soff_q)) ? smean - SONAR_W'(soff_q) : '0;
		end
		if (state_q == ST_SCALE) begin
			diff_le_q <= (diff <= LIDAR_W'(agree_q));
			diff_ge_q <= (diff >= LIDAR_W'(agree_q));
			lprod_q <= l9 * RECIP_10;
			sprod_q <= RECIP_W'(sfilt_q) * RECIP_10;
		end
	end

	assign blend = signed'(lprod_q[RECIP_SHIFT +: ALT_W])
		+ signed'(sprod_q[RECIP_SHIFT +: ALT_W]);

	always_comb begin
		if (lp_q && sp_q) begin
			if (!loor_q && (sfilt_q == '0 || soor_q)) begin
				alt = signed'(ALT_W'(lfilt_q));
			end else if (!soor_q && sfilt_q != '0 && diff_le_q) begin
				alt = blend;
			end else if (loor_q && soor_q) begin
				alt = ALT_NONE;
			end else begin
				alt = signed'(ALT_W'(lfilt_q));
			end
		end else if (lp_q) begin
			alt = signed'(ALT_W'(lfilt_q));
		end else if (sp_q) begin
			alt = signed'(ALT_W'(sfilt_q));
		end else begin
			alt = ALT_NONE;
		end
	end

	always_comb begin
		res.altitude = alt;
		res.lidar_filtered = lfilt_q;
		res.sonar_filtered = sfilt_q;
		res.discrepancy = diff_ge_q && !(sp_q && soor_q);
	end

	a_lfill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lfill_q <= FILL_W'(AVERAGE_DEPTH) && sfill_q <= FILL_W'(AVERAGE_DEPTH))
		else $error("window fill count beyond depth");

	a_empty_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(lfill_q == '0 |-> lsum_q == '0) and (sfill_q == '0 |-> ssum_q == '0))
		else $error("empty window holds a nonzero sum");

	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lslot_q < SLOT_W'(AVERAGE_DEPTH) || AVERAGE_DEPTH == (1 << SLOT_W))
		else $error("lidar write slot out of range");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full queue");

	a_div_pair: assert property (@(posedge clk) disable iff (!arst_n)
		l_done == s_done)
		else $error("window dividers out of step");

endmodule

>>> src/lidar_sonar_altitude_fusion_core.sv
// Path: an accepted item waits in the front register and the command queue; the back end
// pops it, runs the two mean dividers, then its clamp, scale and output states, and pushes
// the result into the result queue. It takes no new item until that push, so the two-bit-per-cycle
// mean dividers set the throughput; the front register and command queue absorb bursts.
// Reset: arst_n clears fill counts, running sums, queues, sequencer and configuration registers
// (agreement window to 50); window contents are not cleared. Uses lsaf_pkg, lsaf_front, lsaf_queue and lsaf_back.
module lidar_sonar_altitude_fusion_core
	import lsaf_pkg::*;
#(
	parameter int AVERAGE_DEPTH = DEF_AVERAGE_DEPTH,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  in_item_t               sample,
	output logic                   full,
	output logic                   empty,
	input  logic                   pop,
	output res_item_t              result,
	input  logic                   cfg_wen,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int CMD_W = $bits(cmd_t);
	localparam int RES_W = $bits(res_item_t);

	logic cmd_push, cmd_full, cmd_pop, cmd_empty;
	cmd_t cmd_in;
	logic [CMD_W-1:0] cmd_rdata;
	logic res_push, res_full;
	res_item_t res_in;
	logic [RES_W-1:0] res_rdata;

	lsaf_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.sample(sample),
		.full(full),
		.cmd_push(cmd_push),
		.cmd(cmd_in),
		.cmd_full(cmd_full)
	);

	lsaf_queue #(.W(CMD_W), .DEPTH(QUEUE_DEPTH)) u_cmd_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(cmd_push),
		.wdata(cmd_in),
		.full(cmd_full),
		.pop(cmd_pop),
		.rdata(cmd_rdata),
		.empty(cmd_empty)
	);

	lsaf_back #(.AVERAGE_DEPTH(AVERAGE_DEPTH)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd_empty(cmd_empty),
		.cmd_pop(cmd_pop),
		.cmd(cmd_t'(cmd_rdata)),
		.res_full(res_full),
		.res_push(res_push),
		.res(res_in)
	);

	lsaf_queue #(.W(RES_W), .DEPTH(QUEUE_DEPTH)) u_res_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.wdata(res_in),
		.full(res_full),
		.pop(pop),
		.rdata(res_rdata),
		.empty(empty)
	);

	assign result = res_item_t'(res_rdata);

endmodule

>>> bench/testbench.sv
// Self-checking testbench for lidar_sonar_altitude_fusion_core: directed and random items,
// register changes between phases, and random idling on both handshakes.
// Depends on lsaf_pkg and the core; predicts every result from its own window model.
module testbench;
	import lsaf_pkg::*;

	localparam int AVG_DEPTH = DEF_AVERAGE_DEPTH;
	localparam int STALL_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 30;
	localparam int PHASE_ITEMS = 160;
	localparam int RANDOM_PHASES = 8;
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
	localparam int LIDAR_MAX = (1 << LIDAR_W) - 1;
	localparam int SONAR_MAX = (1 << SONAR_W) - 1;
	localparam int ITEM_W = $bits(in_item_t);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	in_item_t sample = '0;
	logic full;
	logic empty;
	logic pop = 1'b0;
	res_item_t result;
	logic cfg_wen = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	in_item_t pending[$];
	res_item_t expected[$];
	bit item_taken = 1'b0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int items_queued = 0;
	int results_seen = 0;
	int errors = 0;
	int quiet_cycles = 0;
	int disc_count = 0;
	int none_count = 0;
	int track_cm = 600;

	int lidar_hist[AVG_DEPTH];
	int lidar_fill = 0;
	int lidar_slot = 0;
	int sonar_hist[AVG_DEPTH];
	int sonar_fill = 0;
	int sonar_slot = 0;
	int lidar_ofs = 0;
	int sonar_ofs = 0;
	int agree_win = int'(AGREE_RESET);

	lidar_sonar_altitude_fusion_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.sample(sample),
		.full(full),
		.empty(empty),
		.pop(pop),
		.result(result),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	function automatic res_item_t fuse_altitude(input in_item_t it);
		int i, lsum, ssum, lmean, smean, lf, sf, gap;
		logic lp, sp;
		res_item_t r;
		lsum = 0;
		ssum = 0;
		lp = it.lidar_present;
		sp = it.sonar_present;
		if (lp && !it.lidar_fault) begin
			lidar_hist[lidar_slot] = it.lidar_sample;
			lidar_slot = (lidar_slot == AVG_DEPTH - 1) ? 0 : lidar_slot + 1;
			if (lidar_fill < AVG_DEPTH) lidar_fill++;
		end
		if (sp && !it.sonar_fault) begin
			sonar_hist[sonar_slot] = it.sonar_sample;
			sonar_slot = (sonar_slot == AVG_DEPTH - 1) ? 0 : sonar_slot + 1;
			if (sonar_fill < AVG_DEPTH) sonar_fill++;
		end
		for (i = 0; i < AVG_DEPTH; i++) begin
			lsum += lidar_hist[i];
			ssum += sonar_hist[i];
		end
		lmean = (lidar_fill == 0) ? 0 : lsum / lidar_fill;
		smean = (sonar_fill == 0) ? 0 : ssum / sonar_fill;
		lf = (lmean > lidar_ofs) ? lmean - lidar_ofs : 0;
		sf = (smean > sonar_ofs) ? smean - sonar_ofs : 0;
		gap = (lf > sf) ? lf - sf : sf - lf;
		if (lp && sp) begin
			if (it.lidar_sample != LIDAR_OOR && (sf == 0 || it.sonar_sample == SONAR_OOR)) begin
				r.altitude = ALT_W'(lf);
			end else if (it.sonar_sample != SONAR_OOR && sf != 0 && gap <= agree_win) begin
				r.altitude = ALT_W'((9 * lf) / 10 + sf / 10);
			end else if (it.lidar_sample == LIDAR_OOR && it.sonar_sample == SONAR_OOR) begin
				r.altitude = ALT_NONE;
			end else begin
				r.altitude = ALT_W'(lf);
			end
		end else if (lp) begin
			r.altitude = ALT_W'(lf);
		end else if (sp) begin
			r.altitude = ALT_W'(sf);
		end else begin
			r.altitude = ALT_NONE;
		end
		r.lidar_filtered = LIDAR_W'(lf);
		r.sonar_filtered = SONAR_W'(sf);
		r.discrepancy = (gap >= agree_win) && !(sp && it.sonar_sample == SONAR_OOR);
		return r;
	endfunction

	function automatic in_item_t reading(input logic lp, input logic lflt, input int ls,
			input logic sp, input logic sflt, input int ss);
		in_item_t it;
		it.lidar_present = lp;
		it.lidar_fault = lflt;
		it.lidar_sample = LIDAR_W'(ls);
		it.sonar_present = sp;
		it.sonar_fault = sflt;
		it.sonar_sample = SONAR_W'(ss);
		return it;
	endfunction

	function automatic int clip(input int v, input int hi);
		return (v < 0) ? 0 : (v > hi) ? hi : v;
	endfunction

	// Mostly readings that track a drifting altitude, so both windows agree and blend.
	function automatic in_item_t random_reading();
		int mode, spread, ls, ss;
		mode = $urandom_range(99);
		if (mode >= 85) begin
			return in_item_t'(ITEM_W'($urandom));
		end
		if ($urandom_range(19) == 0) begin
			track_cm = $urandom_range(SONAR_MAX);
		end else begin
			track_cm = clip(track_cm + int'($urandom_range(60)) - 30, SONAR_MAX);
		end
		spread = ($urandom_range(4) == 0) ? 200 : 20;
		ls = clip(track_cm + int'($urandom_range(2 * spread)) - spread, LIDAR_MAX);
		ss = clip(track_cm + int'($urandom_range(2 * spread)) - spread, SONAR_MAX);
		if ($urandom_range(19) == 0) ls = int'(LIDAR_OOR);
		if ($urandom_range(19) == 0) ss = int'(SONAR_OOR);
		return reading($urandom_range(9) != 0, $urandom_range(11) == 0, ls,
			$urandom_range(9) != 0, $urandom_range(11) == 0, ss);
	endfunction

	task automatic queue_item(input in_item_t it);
		pending.push_back(it);
		items_queued++;
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_LIDAR_OFFSET: lidar_ofs = int'(val[OFFSET_W-1:0]);
			CFG_SONAR_OFFSET: sonar_ofs = int'(val[OFFSET_W-1:0]);
			CFG_AGREEMENT_WINDOW: agree_win = int'(val[AGREE_W-1:0]);
			default: ;
		endcase
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic wait_drained();
		while (results_seen != items_queued) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic configure_phase(input int ph);
		case (ph)
			0: begin
				write_reg(CFG_LIDAR_OFFSET, 10'd0);
				write_reg(CFG_SONAR_OFFSET, 10'd0);
				write_reg(CFG_AGREEMENT_WINDOW, 10'd0);
			end
			1: begin
				write_reg(CFG_LIDAR_OFFSET, 10'd181);
				write_reg(CFG_SONAR_OFFSET, 10'd181);
				write_reg(CFG_AGREEMENT_WINDOW, 10'd1023);
			end
			2: begin
				write_reg(CFG_LIDAR_OFFSET, 10'd37);
				write_reg(CFG_SONAR_OFFSET, 10'd120);
				write_reg(CFG_AGREEMENT_WINDOW, 10'd50);
				write_reg(CFG_UNUSED_INDEX, 10'h3FF);
			end
			3: begin
				write_reg(CFG_LIDAR_OFFSET, 10'h3FF);
				write_reg(CFG_SONAR_OFFSET, 10'h2B5);
				write_reg(CFG_AGREEMENT_WINDOW, 10'd200);
			end
			default: begin
				write_reg(CFG_LIDAR_OFFSET, CFG_DATA_W'($urandom_range(181)));
				write_reg(CFG_SONAR_OFFSET, CFG_DATA_W'($urandom_range(181)));
				write_reg(CFG_AGREEMENT_WINDOW, CFG_DATA_W'($urandom_range(120)));
			end
		endcase
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
			pop <= 1'b0;
		end else begin
			if (!push || item_taken) begin
				if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					sample <= pending.pop_front();
					push <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
		item_taken = 1'b0;
	end

	always @(posedge clk) begin
		res_item_t want;
		if (arst_n) begin
			quiet_cycles++;
			if (cfg_wen) quiet_cycles = 0;
			if (push && !full) begin
				expected.push_back(fuse_altitude(sample));
				item_taken = 1'b1;
				quiet_cycles = 0;
			end
			if (pop && !empty) begin
				results_seen++;
				quiet_cycles = 0;
				if (expected.size() == 0) begin
					$display("%0t: result with no item waiting: expected none, actual %p",
						$time, result);
					errors++;
				end else begin
					want = expected.pop_front();
					if (want.discrepancy) disc_count++;
					if (want.altitude == ALT_NONE) none_count++;
					if (result.altitude !== want.altitude) begin
						$display("%0t: altitude expected %0d actual %0d",
							$time, want.altitude, result.altitude);
						errors++;
					end
					if (result.lidar_filtered !== want.lidar_filtered) begin
						$display("%0t: lidar_filtered expected %0d actual %0d",
							$time, want.lidar_filtered, result.lidar_filtered);
						errors++;
					end
					if (result.sonar_filtered !== want.sonar_filtered) begin
						$display("%0t: sonar_filtered expected %0d actual %0d",
							$time, want.sonar_filtered, result.sonar_filtered);
						errors++;
					end
					if (result.discrepancy !== want.discrepancy) begin
						$display("%0t: discrepancy expected %0b actual %0b",
							$time, want.discrepancy, result.discrepancy);
						errors++;
					end
				end
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
				$display("lidar_sonar_altitude_fusion_core verification failed");
				$finish;
			end
		end
	end

	initial begin
		int ph, n;
		for (n = 0; n < AVG_DEPTH; n++) begin
			lidar_hist[n] = 0;
			sonar_hist[n] = 0;
		end
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty sonar window while both are present, then the fusion corner cases.
		queue_item(reading(1, 0, 500, 1, 1, 700));
		queue_item(reading(0, 0, 0, 0, 0, 0));
		queue_item(reading(1, 0, int'(LIDAR_OOR), 1, 0, int'(SONAR_OOR)));
		queue_item(reading(1, 0, LIDAR_MAX, 0, 0, 0));
		queue_item(reading(0, 0, 0, 1, 0, SONAR_MAX));
		queue_item(reading(1, 0, 1000, 1, 0, 1010));
		queue_item(reading(1, 0, int'(LIDAR_OOR), 1, 0, 500));
		queue_item(reading(1, 1, 3000, 1, 0, 900));
		queue_item(reading(1, 0, 800, 1, 1, int'(SONAR_OOR)));
		queue_item(reading(1, 1, 1200, 1, 1, 1300));
		queue_item(reading(1, 0, 3500, 0, 0, 40));
		for (n = 1; n <= 7; n++) begin
			queue_item(reading(1, 0, 100 * n, 1, 0, 100 * n + 20));
		end
		queue_item(reading(1, 0, LIDAR_MAX, 1, 0, SONAR_MAX));
		queue_item(reading(1, 0, 1, 1, 0, 0));
		queue_item(reading(1, 0, 2048, 1, 0, 1024));
		queue_item(reading(1, 1, LIDAR_MAX, 1, 1, SONAR_MAX));
		queue_item(reading(0, 1, 0, 0, 1, int'(SONAR_OOR)));
		wait_drained();

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			configure_phase(ph);
			@(posedge clk);
			send_idle_pct = (ph % 4 == 1) ? 84 : (ph % 4 == 3) ? 28 : 0;
			recv_stall_pct = (ph % 4 == 2) ? 84 : (ph % 4 == 3) ? 28 : 0;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				queue_item(random_reading());
			end
			wait_drained();
		end

		if (expected.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, expected.size());
			errors++;
		end
		$display("Checked %0d results from %0d items over %0d register settings.",
			results_seen, items_queued, RANDOM_PHASES + 1);
		$display("Results with discrepancy set: %0d; with no altitude: %0d.",
			disc_count, none_count);
		if (errors == 0) begin
			$display("lidar_sonar_altitude_fusion_core verification clean");
		end else begin
			$display("lidar_sonar_altitude_fusion_core verification failed");
		end
		$finish;
	end

endmodule
